// ----- rtl/bmhq_pkg.sv -----
// Shared types and constants for the binary min-heap queue unit.
`default_nettype none
package bmhq_pkg;

    localparam int KEY_W        = 32;
    localparam int TAG_W        = 16;
    localparam int ENT_W        = KEY_W + TAG_W;
    localparam int CMP_W        = 32;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [2:0] {
        F_INSERT = 3'd0,
        F_DELETE = 3'd1,
        F_PEEK   = 3'd2,
        F_LOAD   = 3'd3,
        F_BUILD  = 3'd4,
        F_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_EMPTY = 2'd1,
        E_FULL  = 2'd2
    } t_err;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ERR_EMPTY,
        OP_ERR_FULL,
        OP_INS_START,
        OP_INS_RD,
        OP_INS_MOVE,
        OP_WR_V,
        OP_LOAD,
        OP_TOP_RD,
        OP_TOP_OUT,
        OP_RM_RD,
        OP_V_Q,
        OP_SD_L,
        OP_SD_LW,
        OP_SD_RW,
        OP_SD_MOVE,
        OP_BLD_INIT,
        OP_BLD_NEXT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INS_LOOP,
        S_INS_CHK,
        S_TOP_WAIT,
        S_RM,
        S_RM_WAIT,
        S_SD_L,
        S_SD_LW,
        S_SD_RW,
        S_SD_DEC,
        S_BLD_LOOP,
        S_BLD_WAIT,
        S_CLR_LOOP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic lc_ok;
        logic rc_ok;
        logic node_zero;
        logic par_gt;
        logic best_is_node;
        logic empty;
        logic full;
        logic bld_zero;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- rtl/binary_min_heap_queue_unit.sv -----
// Top level of the binary min-heap priority queue unit.
//
//  channel   handshake                  payload
//  request   start & !busy              i_func, i_key, i_tag
//  result    o_done, one cycle          o_out_key, o_out_tag, o_out_valid,
//                                       o_error, o_count, o_compare_total
//
// Insert climbs one level per parent read and key compare. Sift-down works
// one level at a time, each level being one or two reads of the
// single-read-port entry RAM and a key compare; build and clear run
// sift-down once per node or per entry and so scale with count.
// Reset (synchronous, active low) empties the heap and zeroes the compare
// total; RAM contents are not cleared. busy is high from accept through the
// result cycle; the receiver cannot stall, o_done is a one-cycle pulse.
`default_nettype none
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire logic [2:0]       i_func,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [TAG_W-1:0] i_tag,
    output      logic             o_done,
    output      logic [KEY_W-1:0] o_out_key,
    output      logic [TAG_W-1:0] o_out_tag,
    output      logic             o_out_valid,
    output      logic [1:0]       o_error,
    output      logic [CW-1:0]    o_count,
    output      logic [CMP_W-1:0] o_compare_total
);
    t_dp_op   w_op;
    t_dp_stat w_stat;

    // sequencer: walks each operation as a string of datapath commands
    bmhq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_func (i_func),
        .i_stat (w_stat),
        .o_op   (w_op),
        .busy   (busy),
        .o_done (o_done)
    );

    // datapath: entry RAM plus node/child indexes, the sifted entry held in
    // a register (hole method), and the count and compare counters
    bmhq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .o_stat         (w_stat),
        .o_out_key      (o_out_key),
        .o_out_tag      (o_out_tag),
        .o_out_valid    (o_out_valid),
        .o_error        (o_error),
        .o_count        (o_count),
        .o_compare_total(o_compare_total)
    );
endmodule
`default_nettype wire

// ----- rtl/bmhq_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/bmhq_ctrl.sv -----
// Operation sequencer for the heap queue.
`default_nettype none
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic [2:0] i_func,
    input  wire t_dp_stat i_stat,
    output      t_dp_op   o_op,
    output      logic     busy,
    output      logic     o_done
);
    t_state r_state, n_state;
    logic [2:0] r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && start) begin
            r_func <= i_func;
        end
    end

    // where a finished sift-down returns to
    t_state w_ret;
    always_comb begin
        unique case (r_func)
            F_BUILD: w_ret = S_BLD_LOOP;
            F_CLEAR: w_ret = S_CLR_LOOP;
            default: w_ret = S_DONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_CAPTURE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_func)
                    F_INSERT: begin
                        if (i_stat.full) begin
                            o_op = OP_ERR_FULL;  n_state = S_DONE;
                        end else begin
                            o_op = OP_INS_START; n_state = S_INS_LOOP;
                        end
                    end
                    F_DELETE, F_PEEK: begin
                        if (i_stat.empty) begin
                            o_op = OP_ERR_EMPTY; n_state = S_DONE;
                        end else begin
                            o_op = OP_TOP_RD;    n_state = S_TOP_WAIT;
                        end
                    end
                    F_LOAD: begin
                        o_op    = i_stat.full ? OP_ERR_FULL : OP_LOAD;
                        n_state = S_DONE;
                    end
                    F_BUILD: begin
                        o_op = OP_BLD_INIT; n_state = S_BLD_LOOP;
                    end
                    F_CLEAR: n_state = S_CLR_LOOP;
                    default: n_state = S_DONE;
                endcase
            end
            S_INS_LOOP: begin
                if (i_stat.node_zero) begin
                    o_op = OP_WR_V;   n_state = S_DONE;
                end else begin
                    o_op = OP_INS_RD; n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_stat.par_gt) begin
                    o_op = OP_INS_MOVE; n_state = S_INS_LOOP;
                end else begin
                    o_op = OP_WR_V;     n_state = S_DONE;
                end
            end
            S_TOP_WAIT: begin
                o_op    = OP_TOP_OUT;
                n_state = (r_func == F_DELETE) ? S_RM : S_DONE;
            end
            S_RM: begin
                o_op = OP_RM_RD; n_state = S_RM_WAIT;
            end
            S_RM_WAIT: begin
                o_op = OP_V_Q; n_state = S_SD_L;
            end
            S_SD_L: begin
                if (i_stat.lc_ok) begin
                    o_op = OP_SD_L; n_state = S_SD_LW;
                end else begin
                    o_op = OP_WR_V; n_state = w_ret;
                end
            end
            S_SD_LW: begin
                o_op    = OP_SD_LW;
                n_state = i_stat.rc_ok ? S_SD_RW : S_SD_DEC;
            end
            S_SD_RW: begin
                o_op = OP_SD_RW; n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                if (i_stat.best_is_node) begin
                    o_op = OP_WR_V;    n_state = w_ret;
                end else begin
                    o_op = OP_SD_MOVE; n_state = S_SD_L;
                end
            end
            S_BLD_LOOP: begin
                if (i_stat.bld_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_op = OP_BLD_NEXT; n_state = S_BLD_WAIT;
                end
            end
            S_BLD_WAIT: begin
                o_op = OP_V_Q; n_state = S_SD_L;
            end
            S_CLR_LOOP: begin
                if (i_stat.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_op = OP_RM_RD; n_state = S_RM_WAIT;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule
`default_nettype wire

// ----- rtl/bmhq_dp.sv -----
// Heap datapath: entry store, index registers, compare and counters.
`default_nettype none
module bmhq_dp
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_op           i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [TAG_W-1:0] i_tag,
    output      t_dp_stat         o_stat,
    output      logic [KEY_W-1:0] o_out_key,
    output      logic [TAG_W-1:0] o_out_tag,
    output      logic             o_out_valid,
    output      logic [1:0]       o_error,
    output      logic [CW-1:0]    o_count,
    output      logic [CMP_W-1:0] o_compare_total
);
    logic [CW-1:0]    r_cnt;
    logic [CMP_W-1:0] r_cmp;
    logic [AW-1:0]    r_node, r_bidx, r_bld;
    logic [ENT_W-1:0] r_v, r_best;
    logic [KEY_W-1:0] r_okey;
    logic [TAG_W-1:0] r_otag;
    logic             r_oval;
    t_err             r_err;

    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [ENT_W-1:0] w_wdata, w_q;

    bmhq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_q)
    );

    // child and parent indexes, two spare bits so 2i+2 never wraps
    logic [AW+1:0]    w_lc, w_rc, w_cnt_x;
    logic [AW-1:0]    w_par, w_cnt_a, w_cnt_m1;
    logic [KEY_W-1:0] w_qkey, w_vkey, w_bkey;

    assign w_lc     = {1'b0, r_node, 1'b1};
    assign w_rc     = w_lc + (AW+2)'(1);
    assign w_cnt_x  = (AW+2)'(r_cnt);
    assign w_par    = (r_node - AW'(1)) >> 1;
    assign w_cnt_a  = r_cnt[AW-1:0];
    assign w_cnt_m1 = w_cnt_a - AW'(1);
    assign w_qkey   = w_q[ENT_W-1:TAG_W];
    assign w_vkey   = r_v[ENT_W-1:TAG_W];
    assign w_bkey   = r_best[ENT_W-1:TAG_W];

    assign o_stat.lc_ok        = (w_lc < w_cnt_x);
    assign o_stat.rc_ok        = (w_rc < w_cnt_x);
    assign o_stat.node_zero    = (r_node == '0);
    assign o_stat.par_gt       = (w_qkey > w_vkey);
    assign o_stat.best_is_node = (r_bidx == r_node);
    assign o_stat.empty        = (r_cnt == '0);
    assign o_stat.full         = (r_cnt == CW'(CAPACITY));
    assign o_stat.bld_zero     = (r_bld == '0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_node;
        w_wdata = r_v;
        w_raddr = '0;
        case (i_op)
            OP_INS_RD:   w_raddr = w_par;
            OP_INS_MOVE: begin w_we = 1'b1; w_wdata = w_q; end
            OP_WR_V:     w_we = 1'b1;
            OP_LOAD:     begin w_we = 1'b1; w_waddr = w_cnt_a; end
            OP_RM_RD:    w_raddr = w_cnt_m1;
            OP_SD_L:     w_raddr = w_lc[AW-1:0];
            OP_SD_LW:    w_raddr = w_rc[AW-1:0];
            OP_SD_MOVE:  begin w_we = 1'b1; w_wdata = r_best; end
            OP_BLD_NEXT: w_raddr = r_bld - AW'(1);
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_cmp  <= '0;
            r_oval <= 1'b0;
            r_err  <= E_NONE;
        end else begin
            case (i_op)
                OP_CAPTURE: begin
                    r_v    <= {i_key, i_tag};
                    r_okey <= '0;
                    r_otag <= '0;
                    r_oval <= 1'b0;
                    r_err  <= E_NONE;
                end
                OP_ERR_EMPTY: r_err <= E_EMPTY;
                OP_ERR_FULL:  r_err <= E_FULL;
                OP_INS_START: begin
                    r_node <= w_cnt_a;
                    r_cnt  <= r_cnt + CW'(1);
                end
                OP_INS_RD:   r_cmp  <= r_cmp + CMP_W'(1);
                OP_INS_MOVE: r_node <= w_par;
                OP_LOAD:     r_cnt  <= r_cnt + CW'(1);
                OP_TOP_OUT: begin
                    r_okey <= w_qkey;
                    r_otag <= w_q[TAG_W-1:0];
                    r_oval <= 1'b1;
                end
                OP_RM_RD: begin
                    r_cnt  <= r_cnt - CW'(1);
                    r_node <= '0;
                end
                OP_V_Q:  r_v   <= w_q;
                OP_SD_L: r_cmp <= r_cmp + CMP_W'(1);
                OP_SD_LW: begin
                    if (w_qkey < w_vkey) begin
                        r_bidx <= w_lc[AW-1:0];
                        r_best <= w_q;
                    end else begin
                        r_bidx <= r_node;
                        r_best <= r_v;
                    end
                    if (o_stat.rc_ok) begin
                        r_cmp <= r_cmp + CMP_W'(1);
                    end
                end
                OP_SD_RW: begin
                    if (w_qkey < w_bkey) begin
                        r_bidx <= w_rc[AW-1:0];
                        r_best <= w_q;
                    end
                end
                OP_SD_MOVE:  r_node <= r_bidx;
                OP_BLD_INIT: r_bld  <= AW'(r_cnt >> 1);
                OP_BLD_NEXT: begin
                    r_bld  <= r_bld - AW'(1);
                    r_node <= r_bld - AW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_out_key       = r_okey;
    assign o_out_tag       = r_otag;
    assign o_out_valid     = r_oval;
    assign o_error         = r_err;
    assign o_count         = r_cnt;
    assign o_compare_total = r_cmp;
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the binary min-heap queue unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import bmhq_pkg::*;

    localparam int CAP = 64;

    // One predicted result of the heap unit.
    typedef struct packed {
        logic [31:0] okey;
        logic [15:0] otag;
        logic        ovalid;
        logic [1:0]  oerr;
        logic [6:0]  ocount;
        logic [31:0] ocmp;
    } t_heap_resp;

    // One directed stimulus row; chk set when the expected result is typed in.
    typedef struct {
        logic [2:0]  func;
        logic [31:0] key;
        logic [15:0] tag;
        bit          chk;
        t_heap_resp  resp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  i_func = '0;
    logic [31:0] i_key = '0;
    logic [15:0] i_tag = '0;
    wire         busy;
    wire         o_done;
    wire  [31:0] o_out_key;
    wire  [15:0] o_out_tag;
    wire         o_out_valid;
    wire  [1:0]  o_error;
    wire  [6:0]  o_count;
    wire  [31:0] o_compare_total;

    binary_min_heap_queue_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_key(i_key), .i_tag(i_tag), .o_done(o_done),
        .o_out_key(o_out_key), .o_out_tag(o_out_tag), .o_out_valid(o_out_valid),
        .o_error(o_error), .o_count(o_count), .o_compare_total(o_compare_total)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---- predictor state: shadow copy of the heap ----
    logic [31:0] hp_key [CAP];
    logic [15:0] hp_tag [CAP];
    int          hp_n;
    logic [31:0] hp_cmp;

    t_heap_resp  pending_resp[$];
    int          n_fail = 0;
    int          n_req = 0;
    int          n_resp = 0;
    int          n_full = 0;
    int          n_empty = 0;

    function automatic void hp_swap(int a, int b);
        logic [31:0] k;
        logic [15:0] t;
        k = hp_key[a]; t = hp_tag[a];
        hp_key[a] = hp_key[b]; hp_tag[a] = hp_tag[b];
        hp_key[b] = k; hp_tag[b] = t;
    endfunction

    // Push node down; a child wins only on strictly smaller key.
    function automatic void hp_sift_down(int node);
        int lc, rc, best;
        forever begin
            lc = 2 * node + 1;
            rc = 2 * node + 2;
            best = node;
            if (lc < hp_n) begin
                hp_cmp++;
                if (hp_key[lc] < hp_key[node]) best = lc;
            end
            if (rc < hp_n) begin
                hp_cmp++;
                if (hp_key[rc] < hp_key[best]) best = rc;
            end
            if (best == node) return;
            hp_swap(node, best);
            node = best;
        end
    endfunction

    function automatic void hp_pop();
        hp_n--;
        hp_key[0] = hp_key[hp_n];
        hp_tag[0] = hp_tag[hp_n];
        hp_sift_down(0);
    endfunction

    // Advance the shadow heap by one request and return its result.
    function automatic t_heap_resp heap_predict(logic [2:0] f, logic [31:0] k,
                                                logic [15:0] t);
        t_heap_resp r;
        int i, par;
        r = '{okey: '0, otag: '0, ovalid: 1'b0, oerr: E_NONE, ocount: '0, ocmp: '0};
        case (f)
            F_INSERT: begin
                if (hp_n >= CAP) r.oerr = E_FULL;
                else begin
                    i = hp_n;
                    hp_n++;
                    while (i > 0) begin
                        par = (i - 1) / 2;
                        hp_cmp++;
                        if (!(hp_key[par] > k)) break;
                        hp_key[i] = hp_key[par];
                        hp_tag[i] = hp_tag[par];
                        i = par;
                    end
                    hp_key[i] = k;
                    hp_tag[i] = t;
                end
            end
            F_DELETE, F_PEEK: begin
                if (hp_n == 0) r.oerr = E_EMPTY;
                else begin
                    r.okey = hp_key[0];
                    r.otag = hp_tag[0];
                    r.ovalid = 1'b1;
                    if (f == F_DELETE) hp_pop();
                end
            end
            F_LOAD: begin
                if (hp_n >= CAP) r.oerr = E_FULL;
                else begin
                    hp_key[hp_n] = k;
                    hp_tag[hp_n] = t;
                    hp_n++;
                end
            end
            F_BUILD: begin
                for (i = hp_n / 2 - 1; i >= 0; i--) hp_sift_down(i);
            end
            F_CLEAR: begin
                while (hp_n != 0) hp_pop();
            end
            default: ;
        endcase
        r.ocount = 7'(hp_n);
        r.ocmp = hp_cmp;
        return r;
    endfunction

    // ---- request driver ----
    // Holds start until accepted; drops it after unless next request follows.
    task automatic send_request(logic [2:0] f, logic [31:0] k, logic [15:0] t,
                                bit chk, t_heap_resp typed);
        t_heap_resp p;
        p = heap_predict(f, k, t);
        if (chk && p != typed) begin
            $display("%0t: directed row disagrees with predictor, func %0d", $realtime, f);
            n_fail++;
        end
        start  <= 1'b1;
        i_func <= f;
        i_key  <= k;
        i_tag  <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        pending_resp.push_back(chk ? typed : p);
        n_req++;
        if (p.oerr == E_FULL) n_full++;
        if (p.oerr == E_EMPTY) n_empty++;
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // ---- result checker: strobe sampled at the edge ----
    always @(posedge i_clk) begin
        t_heap_resp e;
        if (i_rst_n && o_done) begin
            n_resp++;
            if (pending_resp.size() == 0) begin
                $display("%0t: result with no request pending", $realtime);
                n_fail++;
            end else begin
                e = pending_resp.pop_front();
                if (o_out_key !== e.okey) begin
                    $display("%0t: out_key exp %h got %h", $realtime, e.okey, o_out_key);
                    n_fail++;
                end
                if (o_out_tag !== e.otag) begin
                    $display("%0t: out_tag exp %h got %h", $realtime, e.otag, o_out_tag);
                    n_fail++;
                end
                if (o_out_valid !== e.ovalid) begin
                    $display("%0t: out_valid exp %b got %b", $realtime, e.ovalid,
                             o_out_valid);
                    n_fail++;
                end
                if (o_error !== e.oerr) begin
                    $display("%0t: error exp %0d got %0d", $realtime, e.oerr, o_error);
                    n_fail++;
                end
                if (o_count !== e.ocount) begin
                    $display("%0t: count exp %0d got %0d", $realtime, e.ocount, o_count);
                    n_fail++;
                end
                if (o_compare_total !== e.ocmp) begin
                    $display("%0t: compare_total exp %0d got %0d", $realtime, e.ocmp,
                             o_compare_total);
                    n_fail++;
                end
            end
        end
    end

    // Random key; narrow ranges often so equal keys are common.
    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 7));
            1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] rand_func(int fill);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return 3'($urandom_range(6, 7));
        if (r < 4) return F_CLEAR;
        if (r < 8) return F_BUILD;
        if (r < 14) return F_PEEK;
        // bias toward filling when short, draining when at least half full
        if (r < 14 + (fill < 32 ? 25 : 50)) return F_DELETE;
        if (r < 72) return F_LOAD;
        return F_INSERT;
    endfunction

    t_row dir_rows[$];

    function automatic t_heap_resp typed_resp(logic [31:0] k, logic [15:0] t, logic v,
                                              logic [1:0] e, int c, int cmp);
        t_heap_resp r;
        r = '{okey: k, otag: t, ovalid: v, oerr: e, ocount: 7'(c), ocmp: 32'(cmp)};
        return r;
    endfunction

    initial begin
        t_heap_resp none_resp;
        int burst, i, fill;
        logic [2:0] f;
        hp_n = 0;
        hp_cmp = '0;
        none_resp = '0;
        // Directed table: errors on empty, extremes, equal keys, build, clear.
        dir_rows.push_back('{F_DELETE, 32'h0, 16'h0, 1, typed_resp(0, 0, 0, E_EMPTY, 0, 0)});
        dir_rows.push_back('{F_PEEK, 32'hFFFF_FFFF, 16'hFFFF, 1,
                             typed_resp(0, 0, 0, E_EMPTY, 0, 0)});
        dir_rows.push_back('{F_CLEAR, 32'h0, 16'h0, 1, typed_resp(0, 0, 0, E_NONE, 0, 0)});
        dir_rows.push_back('{F_BUILD, 32'h0, 16'h0, 1, typed_resp(0, 0, 0, E_NONE, 0, 0)});
        dir_rows.push_back('{3'd6, 32'h0, 16'h0, 1, typed_resp(0, 0, 0, E_NONE, 0, 0)});
        dir_rows.push_back('{3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1,
                             typed_resp(0, 0, 0, E_NONE, 0, 0)});
        dir_rows.push_back('{F_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1,
                             typed_resp(0, 0, 0, E_NONE, 1, 0)});
        dir_rows.push_back('{F_PEEK, 32'h0, 16'h0, 1,
                             typed_resp(32'hFFFF_FFFF, 16'hFFFF, 1, E_NONE, 1, 0)});
        dir_rows.push_back('{F_INSERT, 32'h0, 16'h0, 0, none_resp});
        dir_rows.push_back('{F_INSERT, 32'h0, 16'h1234, 0, none_resp});
        dir_rows.push_back('{F_INSERT, 32'h5, 16'hA5A5, 0, none_resp});
        dir_rows.push_back('{F_DELETE, 32'h0, 16'h0, 0, none_resp});
        dir_rows.push_back('{F_LOAD, 32'h9, 16'h5A5A, 0, none_resp});
        dir_rows.push_back('{F_LOAD, 32'h1, 16'h0001, 0, none_resp});
        dir_rows.push_back('{F_LOAD, 32'h1, 16'h0002, 0, none_resp});
        dir_rows.push_back('{F_BUILD, 32'h0, 16'h0, 0, none_resp});
        dir_rows.push_back('{F_DELETE, 32'h0, 16'h0, 0, none_resp});
        dir_rows.push_back('{F_CLEAR, 32'h0, 16'h0, 0, none_resp});
        dir_rows.push_back('{F_LOAD, 32'h7, 16'h7, 0, none_resp});
        dir_rows.push_back('{F_BUILD, 32'h0, 16'h0, 0, none_resp});
        dir_rows.push_back('{F_DELETE, 32'h0, 16'h0, 0, none_resp});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[j]) begin
            send_request(dir_rows[j].func, dir_rows[j].key, dir_rows[j].tag,
                         dir_rows[j].chk, dir_rows[j].resp);
            if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 3));
        end

        // Fill to capacity, then hit the full error on both write paths.
        for (i = 0; i < CAP; i++)
            send_request($urandom_range(0, 1) ? F_INSERT : F_LOAD, rand_key(),
                         16'($urandom()), 0, none_resp);
        send_request(F_INSERT, 32'h0, 16'hFFFF, 0, none_resp);
        send_request(F_LOAD, 32'hFFFF_FFFF, 16'h0, 0, none_resp);
        send_request(F_BUILD, 32'h0, 16'h0, 0, none_resp);
        send_request(F_CLEAR, 32'h0, 16'h0, 0, none_resp);
        idle_gap(1);
        // Pause until the unit has drained every pending result.
        while (pending_resp.size() != 0) @(posedge i_clk);

        // Random bursts with random gaps.
        i = 0;
        while (i < 760) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && i < 760) begin
                fill = hp_n;
                f = rand_func(fill);
                send_request(f, rand_key(), 16'($urandom()), 0, none_resp);
                burst--;
                i++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
        end
        idle_gap(1);

        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("requests %0d, results %0d, full errors %0d, empty errors %0d",
                 n_req, n_resp, n_full, n_empty);
        $display("final compare total %0d, heap depth %0d", hp_cmp, hp_n);
        if (n_fail == 0 && pending_resp.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog: worst case is far below this.
    initial begin
        #40000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
